// ===== rtl/mtes_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Timer table package
// Shared types, command and result codes, and sizing constants for the
// multi-slot timer table with expiry scan.
// ----------------------------------------------------------------------------
package mtes_pkg;

    // Number of timer slots and the width of a slot index into the table.
    localparam int SLOTS     = 16;
    localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SLOT_LAST = SLOTS - 1;

    // Command codes of the input item.
    localparam logic [1:0] CMD_SCAN  = 2'd0;
    localparam logic [1:0] CMD_ARM   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Result kinds.
    localparam logic [1:0] KIND_FIRE = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_ACK  = 2'd2;

    // Register map (byte addresses).
    localparam int          PADDR_W           = 2;
    localparam logic [1:0]  ADDR_DEFAULT_WAIT = 2'd0;
    localparam logic [15:0] DEFAULT_WAIT_RST  = 16'd200;

    // Rearm step in ms for a zero interval, and the rearm offset.
    localparam logic [27:0] REARM_MIN_STEP = 28'd6;
    localparam logic [27:0] REARM_OFFSET   = 28'd6;
    // Rounding term added to the ms distance before dividing by ten.
    localparam logic [32:0] ROUND_MS       = 33'd5;
    // Reciprocal of ten in 23 fractional bits, rounded down.
    localparam logic [19:0] DIV10_RECIP    = 20'd838860;

    typedef struct packed {
        logic [1:0]  command;
        logic [3:0]  slot;
        logic [31:0] now_ms;
        logic [31:0] expire_ms;
        logic [23:0] interval_cs;
        logic        keep_flag;
        logic        reset_flag;
        logic [31:0] timer_id;
    } cmd_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  fired_slot;
        logic [31:0] fired_id;
        logic [15:0] next_wait_cs;
        logic        last;
    } res_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACK,
        ST_READ,
        ST_EVAL,
        ST_BID,
        ST_DIV,
        ST_FIX,
        ST_DONE
    } mtes_state_t;

endpackage
`default_nettype wire

// ===== rtl/multi_timer_expiry_scan.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Multi-slot timer table with expiry scan
// Holds a table of one-shot and periodic timers, arms and clears slots, and
// scans the table against the current time to report fired timers and the
// wait until the next scan.
// ----------------------------------------------------------------------------
// An arm or clear command is taken on transfer, and the ST_ACK state then
// presents the acknowledge. A scan visits the slots one after another
// through a single slot datapath (one 33-bit subtract, one add and one
// compare, each in its own state): an empty or disabled slot passes only
// ST_READ, a slot that fires and is freed or disabled passes ST_READ and
// ST_EVAL, and a pending or rearmed slot passes ST_READ, ST_EVAL and ST_BID.
// ST_DIV and ST_FIX then turn the smallest distance into centiseconds and
// ST_DONE presents the scan-done result; the result side can stall it. The
// command side is stalled until the last result of the current command has
// been loaded into the output register.
module multi_timer_expiry_scan
(
    input  wire                                 clk,
    input  wire                                 rst_n,
    // Command channel
    input  wire                                 cmd_valid,
    output logic                                cmd_stall,
    input  mtes_pkg::cmd_item_t                 cmd_item,
    // Result channel
    output logic                                res_valid,
    input  wire                                 res_stall,
    output mtes_pkg::res_item_t                 res_item,
    // Configuration port
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire  [mtes_pkg::PADDR_W-1:0]        paddr,
    input  wire  [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    // Slot table
    logic                           valid_reg    [mtes_pkg::SLOTS];
    logic                           disabled_reg [mtes_pkg::SLOTS];
    logic                           keep_reg     [mtes_pkg::SLOTS];
    logic                           rearm_reg    [mtes_pkg::SLOTS];
    logic [31:0]                    expiry_reg   [mtes_pkg::SLOTS];
    logic [23:0]                    interval_reg [mtes_pkg::SLOTS];
    logic [31:0]                    ident_reg    [mtes_pkg::SLOTS];

    // Sequencer and scan datapath
    mtes_pkg::mtes_state_t          state_reg, state_next;
    logic [mtes_pkg::IDX_W-1:0]     idx_reg, idx_next;
    logic [31:0]                    now_reg, now_next;
    logic [32:0]                    diff_reg, diff_next;
    logic [27:0]                    step_reg, step_next;
    logic [32:0]                    bid_reg, bid_next;
    logic [32:0]                    dmin_reg, dmin_next;
    logic [39:0]                    prod_reg, prod_next;
    logic                           small_reg, small_next;
    logic [15:0]                    wait_reg, wait_next;
    logic [15:0]                    default_wait_reg;

    // Output register
    logic                           res_valid_reg, res_valid_next;
    mtes_pkg::res_item_t            res_item_reg, res_item_next;

    // Table write controls
    logic                           tbl_arm;
    logic                           tbl_clear;
    logic                           tbl_free;
    logic                           tbl_disable;
    logic                           tbl_rearm;
    logic [31:0]                    new_expiry;

    // Helper signals
    logic                           cmd_accept;
    logic                           res_free;
    logic                           slot_in_range;
    logic [mtes_pkg::IDX_W-1:0]     cmd_idx;
    logic                           cur_live;
    logic                           expired;
    logic                           last_slot;
    logic [27:0]                    step_calc;
    logic [32:0]                    rearm_sum;
    logic                           rearm_sat;
    logic [19:0]                    limit_ms;
    logic [15:0]                    quot_est;
    logic [19:0]                    quot_x10;
    logic [19:0]                    rem_ms;
    logic [15:0]                    quot;
    logic [15:0]                    wait_sel;
    logic                           cfg_write;

    // Handshake helpers.
    assign cmd_stall  = (state_reg != mtes_pkg::ST_IDLE);
    assign cmd_accept = cmd_valid && !cmd_stall;
    assign res_free   = !res_valid_reg || !res_stall;
    assign res_valid  = res_valid_reg;
    assign res_item   = res_item_reg;

    // Slot index of an arm or clear command.
    assign slot_in_range = (32'(cmd_item.slot) < 32'(mtes_pkg::SLOTS));
    assign cmd_idx       = mtes_pkg::IDX_W'(cmd_item.slot);

    // Current slot of the scan.
    assign cur_live  = valid_reg[idx_reg] && !disabled_reg[idx_reg];
    assign last_slot = (idx_reg == '0);

    // The slot has expired when the signed distance is zero or negative.
    assign expired = diff_reg[32] || (diff_reg == '0);

    // Rearm step: interval times ten minus the offset, or the minimum step.
    assign step_calc = (interval_reg[idx_reg] == '0) ? mtes_pkg::REARM_MIN_STEP :
        ((28'(interval_reg[idx_reg]) << 3) + (28'(interval_reg[idx_reg]) << 1)
         - mtes_pkg::REARM_OFFSET);

    // New expiry of a rearmed slot, saturating at the top of the time range.
    assign rearm_sum  = {1'b0, now_reg} + 33'(step_reg);
    assign rearm_sat  = rearm_sum[32];
    assign new_expiry = rearm_sat ? '1 : rearm_sum[31:0];

    // Default wait in ms: a smaller distance wins over the default.
    assign limit_ms = (20'(default_wait_reg) << 3) + (20'(default_wait_reg) << 1);

    // Divide the smallest distance by ten: the estimate is exact or one low,
    // and a single correction step fixes it.
    assign quot_est = prod_reg[38:23];
    assign quot_x10 = (20'(quot_est) << 3) + (20'(quot_est) << 1);
    assign rem_ms   = dmin_reg[19:0] - quot_x10;
    assign quot     = (rem_ms >= 20'd10) ? (quot_est + 16'd1) : quot_est;
    assign wait_sel = small_reg ? quot : default_wait_reg;

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mtes_pkg::ST_IDLE:
            begin
                if (cmd_accept)
                begin
                    if (cmd_item.command == mtes_pkg::CMD_SCAN)
                        state_next = mtes_pkg::ST_READ;
                    else
                        state_next = mtes_pkg::ST_ACK;
                end
            end
            mtes_pkg::ST_ACK:
            begin
                if (res_free)
                    state_next = mtes_pkg::ST_IDLE;
            end
            mtes_pkg::ST_READ:
            begin
                if (cur_live)
                    state_next = mtes_pkg::ST_EVAL;
                else if (last_slot)
                    state_next = mtes_pkg::ST_DIV;
            end
            mtes_pkg::ST_EVAL:
            begin
                if (!expired)
                    state_next = mtes_pkg::ST_BID;
                else if (res_free)
                begin
                    if (keep_reg[idx_reg] && rearm_reg[idx_reg])
                        state_next = mtes_pkg::ST_BID;
                    else if (last_slot)
                        state_next = mtes_pkg::ST_DIV;
                    else
                        state_next = mtes_pkg::ST_READ;
                end
            end
            mtes_pkg::ST_BID:
            begin
                if (last_slot)
                    state_next = mtes_pkg::ST_DIV;
                else
                    state_next = mtes_pkg::ST_READ;
            end
            mtes_pkg::ST_DIV:
            begin
                state_next = mtes_pkg::ST_FIX;
            end
            mtes_pkg::ST_FIX:
            begin
                state_next = mtes_pkg::ST_DONE;
            end
            mtes_pkg::ST_DONE:
            begin
                if (res_free)
                    state_next = mtes_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mtes_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath, table controls and result loading for each state.
    always_comb
    begin
        idx_next       = idx_reg;
        now_next       = now_reg;
        diff_next      = diff_reg;
        step_next      = step_reg;
        bid_next       = bid_reg;
        dmin_next      = dmin_reg;
        prod_next      = prod_reg;
        small_next     = small_reg;
        wait_next      = wait_reg;
        tbl_arm        = 1'b0;
        tbl_clear      = 1'b0;
        tbl_free       = 1'b0;
        tbl_disable    = 1'b0;
        tbl_rearm      = 1'b0;
        res_valid_next = res_valid_reg && res_stall;
        res_item_next  = res_item_reg;
        case (state_reg)
            mtes_pkg::ST_IDLE:
            begin
                if (cmd_accept)
                begin
                    idx_next  = mtes_pkg::IDX_W'(mtes_pkg::SLOT_LAST);
                    now_next  = cmd_item.now_ms;
                    dmin_next = '1;
                    tbl_arm   = slot_in_range && (cmd_item.command == mtes_pkg::CMD_ARM);
                    tbl_clear = slot_in_range && (cmd_item.command == mtes_pkg::CMD_CLEAR);
                end
            end
            mtes_pkg::ST_ACK:
            begin
                if (res_free)
                begin
                    res_valid_next = 1'b1;
                    res_item_next  = '{kind: mtes_pkg::KIND_ACK, fired_slot: '0,
                                       fired_id: '0, next_wait_cs: '0, last: 1'b1};
                end
            end
            mtes_pkg::ST_READ:
            begin
                // Signed distance to expiry and the rearm step of this slot.
                diff_next = {1'b0, expiry_reg[idx_reg]} - {1'b0, now_reg};
                step_next = step_calc;
                if (!cur_live && !last_slot)
                    idx_next = idx_reg - mtes_pkg::IDX_W'(1);
            end
            mtes_pkg::ST_EVAL:
            begin
                if (!expired)
                begin
                    bid_next = diff_reg + mtes_pkg::ROUND_MS;
                end
                else if (res_free)
                begin
                    res_valid_next = 1'b1;
                    res_item_next  = '{kind: mtes_pkg::KIND_FIRE,
                                       fired_slot: 4'(idx_reg),
                                       fired_id: ident_reg[idx_reg],
                                       next_wait_cs: '0, last: 1'b0};
                    if (!keep_reg[idx_reg])
                        tbl_free = 1'b1;
                    else if (!rearm_reg[idx_reg])
                        tbl_disable = 1'b1;
                    else
                    begin
                        tbl_rearm = 1'b1;
                        bid_next  = rearm_sat ?
                            ({1'b0, ~now_reg} + mtes_pkg::ROUND_MS) :
                            (33'(step_reg) + mtes_pkg::ROUND_MS);
                    end
                    if (!(keep_reg[idx_reg] && rearm_reg[idx_reg]) && !last_slot)
                        idx_next = idx_reg - mtes_pkg::IDX_W'(1);
                end
            end
            mtes_pkg::ST_BID:
            begin
                if (bid_reg < dmin_reg)
                    dmin_next = bid_reg;
                if (!last_slot)
                    idx_next = idx_reg - mtes_pkg::IDX_W'(1);
            end
            mtes_pkg::ST_DIV:
            begin
                small_next = (dmin_reg < 33'(limit_ms));
                prod_next  = 40'(dmin_reg[19:0]) * 40'(mtes_pkg::DIV10_RECIP);
            end
            mtes_pkg::ST_FIX:
            begin
                wait_next = (wait_sel == '0) ? 16'd1 : wait_sel;
            end
            mtes_pkg::ST_DONE:
            begin
                if (res_free)
                begin
                    res_valid_next = 1'b1;
                    res_item_next  = '{kind: mtes_pkg::KIND_DONE, fired_slot: '0,
                                       fired_id: '0, next_wait_cs: wait_reg,
                                       last: 1'b1};
                end
            end
            default:
            begin
                res_valid_next = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mtes_pkg::ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        now_reg      <= now_next;
        diff_reg     <= diff_next;
        step_reg     <= step_next;
        bid_reg      <= bid_next;
        dmin_reg     <= dmin_next;
        prod_reg     <= prod_next;
        small_reg    <= small_next;
        wait_reg     <= wait_next;
        res_item_reg <= res_item_next;
    end

    // Slot valid and disabled marks.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mtes_pkg::SLOTS; i++)
            begin
                valid_reg[i]    <= 1'b0;
                disabled_reg[i] <= 1'b0;
            end
        end
        else if (tbl_arm)
        begin
            valid_reg[cmd_idx]    <= 1'b1;
            disabled_reg[cmd_idx] <= 1'b0;
        end
        else if (tbl_clear)
        begin
            valid_reg[cmd_idx] <= 1'b0;
        end
        else if (tbl_free)
        begin
            valid_reg[idx_reg] <= 1'b0;
        end
        else if (tbl_disable)
        begin
            disabled_reg[idx_reg] <= 1'b1;
        end
    end

    // Slot contents, loaded by an arm and updated by a rearm.
    always_ff @(posedge clk)
    begin
        if (tbl_arm)
        begin
            keep_reg[cmd_idx]     <= cmd_item.keep_flag;
            rearm_reg[cmd_idx]    <= cmd_item.reset_flag;
            expiry_reg[cmd_idx]   <= cmd_item.expire_ms;
            interval_reg[cmd_idx] <= cmd_item.interval_cs;
            ident_reg[cmd_idx]    <= cmd_item.timer_id;
        end
        else if (tbl_rearm)
        begin
            expiry_reg[idx_reg] <= new_expiry;
        end
    end

    // Configuration register.
    assign cfg_write = psel && penable && pwrite && (paddr == mtes_pkg::ADDR_DEFAULT_WAIT);
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            default_wait_reg <= mtes_pkg::DEFAULT_WAIT_RST;
        else if (cfg_write)
            default_wait_reg <= pwdata[15:0];
    end

    // Register read data.
    always_comb
    begin
        if (paddr == mtes_pkg::ADDR_DEFAULT_WAIT)
            prdata = {16'd0, default_wait_reg};
        else
            prdata = '0;
    end

`ifndef SYNTHESIS
    // A scan command always starts by reading the top slot.
    a_scan_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_accept && (cmd_item.command == mtes_pkg::CMD_SCAN))
        |=> ((state_reg == mtes_pkg::ST_READ)
             && (idx_reg == mtes_pkg::IDX_W'(mtes_pkg::SLOT_LAST))))
        else $error("scan did not start at the top slot");

    // A fired timer is never the final result of a command.
    a_fire_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res_item.kind == mtes_pkg::KIND_FIRE)) |-> !res_item.last)
        else $error("fire result marked as last");

    // The computed wait is at least one and never above a nonzero default.
    a_wait_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mtes_pkg::ST_FIX)
        |=> ((wait_reg != '0)
             && ((wait_reg <= default_wait_reg) || (default_wait_reg == '0))))
        else $error("scan wait out of bounds");

    // The smallest distance never grows during a scan.
    a_dmin_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg != mtes_pkg::ST_IDLE) && $past(state_reg != mtes_pkg::ST_IDLE))
        |-> (dmin_reg <= $past(dmin_reg)))
        else $error("smallest distance increased");
`endif

endmodule
`default_nettype wire

// ===== tb/multi_timer_expiry_scan_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer table expiry scan testbench
// Drives arm, clear and scan commands into the timer table with bursty
// transfers and a stalling result side. A scoreboard class keeps its own copy
// of the slot table and the default wait register, predicts the fire, done
// and acknowledge results of every accepted command, and compares each
// result against the oldest prediction.
// ----------------------------------------------------------------------------
module multi_timer_expiry_scan_tb;

    // Command code that the block acknowledges but otherwise ignores.
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;
    localparam int         PHASE_ITEMS = 48;
    localparam int         LONG_HOLD   = 400;
    localparam int         SETTLE      = 60;

    // Scoreboard: slot table copy, result prediction and result compare.
    class expiry_scoreboard;
        bit [15:0] wait_reg;
        bit        armed    [mtes_pkg::SLOTS];
        bit        off      [mtes_pkg::SLOTS];
        bit        keep     [mtes_pkg::SLOTS];
        bit        rearm    [mtes_pkg::SLOTS];
        bit [31:0] expiry   [mtes_pkg::SLOTS];
        bit [23:0] interval [mtes_pkg::SLOTS];
        bit [31:0] ident    [mtes_pkg::SLOTS];
        mtes_pkg::res_item_t expected_q [$];
        int        errors;

        function new();
            wait_reg = mtes_pkg::DEFAULT_WAIT_RST;
            errors   = 0;
            foreach (armed[i])
            begin
                armed[i] = 1'b0;
                off[i]   = 1'b0;
            end
        endfunction

        task report(string msg);
            $display("%0t ns: mismatch: %s", $time, msg);
            errors++;
        endtask

        function void queue_result(logic [1:0] kind, logic [3:0] slot_idx,
                                   logic [31:0] id, logic [15:0] wait_cs,
                                   logic last_flag);
            mtes_pkg::res_item_t r;
            r.kind         = kind;
            r.fired_slot   = slot_idx;
            r.fired_id     = id;
            r.next_wait_cs = wait_cs;
            r.last         = last_flag;
            expected_q.push_back(r);
        endfunction

        // Predict the results of one accepted command and update the table.
        function void note_command(mtes_pkg::cmd_item_t c);
            logic [63:0] best;
            logic [63:0] bid_cs;
            logic [63:0] next_exp;
            if (c.command == mtes_pkg::CMD_SCAN)
            begin
                best = 64'(wait_reg);
                for (int n = mtes_pkg::SLOTS - 1; n >= 0; n--)
                begin
                    if (!armed[n] || off[n])
                        continue;
                    // A pending slot only bids for the next wait.
                    if (expiry[n] > c.now_ms)
                    begin
                        bid_cs = (64'(expiry[n]) - 64'(c.now_ms) + 64'd5) / 64'd10;
                        if (bid_cs < best)
                            best = bid_cs;
                        continue;
                    end
                    queue_result(mtes_pkg::KIND_FIRE, 4'(n), ident[n], 16'd0, 1'b0);
                    if (!keep[n])
                    begin
                        armed[n] = 1'b0;
                        continue;
                    end
                    if (!rearm[n])
                    begin
                        off[n] = 1'b1;
                        continue;
                    end
                    // Periodic slot: new expiry saturates at the top of the range.
                    next_exp = 64'(c.now_ms) + ((interval[n] != 24'd0) ?
                               64'(interval[n]) * 64'd10 - 64'd6 : 64'd6);
                    if (next_exp > 64'hFFFF_FFFF)
                        next_exp = 64'hFFFF_FFFF;
                    expiry[n] = next_exp[31:0];
                    bid_cs = (next_exp - 64'(c.now_ms) + 64'd5) / 64'd10;
                    if (bid_cs < best)
                        best = bid_cs;
                end
                if (best < 64'd1)
                    best = 64'd1;
                queue_result(mtes_pkg::KIND_DONE, 4'd0, 32'd0, best[15:0], 1'b1);
            end
            else
            begin
                if (int'(c.slot) < mtes_pkg::SLOTS)
                begin
                    if (c.command == mtes_pkg::CMD_ARM)
                    begin
                        armed[c.slot]    = 1'b1;
                        off[c.slot]      = 1'b0;
                        expiry[c.slot]   = c.expire_ms;
                        interval[c.slot] = c.interval_cs;
                        keep[c.slot]     = c.keep_flag;
                        rearm[c.slot]    = c.reset_flag;
                        ident[c.slot]    = c.timer_id;
                    end
                    else if (c.command == mtes_pkg::CMD_CLEAR)
                    begin
                        armed[c.slot] = 1'b0;
                    end
                end
                queue_result(mtes_pkg::KIND_ACK, 4'd0, 32'd0, 16'd0, 1'b1);
            end
        endfunction

        task check_field(string name, logic [31:0] got_v, logic [31:0] exp_v);
            if (got_v !== exp_v)
                report($sformatf("%s got %h, expected %h", name, got_v, exp_v));
        endtask

        // Compare one accepted result with the oldest prediction.
        task check_result(mtes_pkg::res_item_t got);
            mtes_pkg::res_item_t exp_r;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected result kind %h slot %h id %h wait %h",
                                 got.kind, got.fired_slot, got.fired_id,
                                 got.next_wait_cs));
                return;
            end
            exp_r = expected_q.pop_front();
            check_field("kind", 32'(got.kind), 32'(exp_r.kind));
            check_field("fired_slot", 32'(got.fired_slot), 32'(exp_r.fired_slot));
            check_field("fired_id", got.fired_id, exp_r.fired_id);
            check_field("next_wait_cs", 32'(got.next_wait_cs), 32'(exp_r.next_wait_cs));
            check_field("last", 32'(got.last), 32'(exp_r.last));
        endtask
    endclass

    logic                 clk;
    logic                 rst_n       = 1'b0;
    logic                 cmd_valid   = 1'b0;
    logic                 cmd_stall;
    mtes_pkg::cmd_item_t  cmd_item    = '0;
    logic                 res_valid;
    logic                 res_stall   = 1'b0;
    mtes_pkg::res_item_t  res_item;
    logic                 psel        = 1'b0;
    logic                 penable     = 1'b0;
    logic                 pwrite      = 1'b0;
    logic [mtes_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0]          pwdata      = '0;
    logic [31:0]          prdata;
    logic                 pready;

    expiry_scoreboard     sb;
    logic [31:0]          clock_ms;
    int                   burst_left  = 0;
    bit                   hold_request = 1'b0;

    multi_timer_expiry_scan i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // 8 ns clock.
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Run limit.
    initial
    begin
        #5_000_000;
        $display("multi_timer_expiry_scan_tb: FAIL");
        $finish;
    end

    // Result side: changing stall patterns, plus a long hold-off on request.
    initial
    begin
        int mode;
        int span;
        int cycle;
        span  = 0;
        cycle = 0;
        mode  = 0;
        forever
        begin
            @(posedge clk);
            cycle++;
            if (hold_request)
            begin
                hold_request = 1'b0;
                res_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                if (span == 0)
                begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(20, 120);
                end
                span--;
                case (mode)
                    0:       res_stall <= 1'b0;
                    1:       res_stall <= ($urandom_range(0, 3) == 0);
                    2:       res_stall <= ($urandom_range(0, 3) != 0);
                    default: res_stall <= ((cycle % 5) < 2);
                endcase
            end
        end
    end

    // Check every result transfer.
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            sb.check_result(res_item);
    end

    // Offer one command and wait for its transfer.
    task automatic send_command(mtes_pkg::cmd_item_t c);
        cmd_item  <= c;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        sb.note_command(c);
    endtask

    // Commands go out in bursts of random length with random gaps between them.
    task automatic issue(mtes_pkg::cmd_item_t c);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                cmd_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        send_command(c);
    endtask

    // Stop offering commands until every predicted result has arrived.
    task automatic drain();
        cmd_valid <= 1'b0;
        burst_left = 0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [mtes_pkg::PADDR_W-1:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Change the default wait while the block is idle, then read it back.
    task automatic set_default_wait(logic [15:0] value);
        logic [31:0] rd;
        drain();
        repeat (8) @(posedge clk);
        apb_access(1'b1, mtes_pkg::ADDR_DEFAULT_WAIT, {16'd0, value}, rd);
        sb.wait_reg = value;
        apb_access(1'b0, mtes_pkg::ADDR_DEFAULT_WAIT, 32'd0, rd);
        if (rd[15:0] !== value)
            sb.report($sformatf("default_wait read %h, expected %h", rd[15:0], value));
    endtask

    // Random contents in every field; callers overwrite what they use.
    function automatic mtes_pkg::cmd_item_t random_fill();
        mtes_pkg::cmd_item_t c;
        c.command     = 2'($urandom_range(0, 3));
        c.slot        = 4'($urandom);
        c.now_ms      = $urandom;
        c.expire_ms   = $urandom;
        c.interval_cs = 24'($urandom);
        c.keep_flag   = 1'($urandom);
        c.reset_flag  = 1'($urandom);
        c.timer_id    = $urandom;
        return c;
    endfunction

    function automatic mtes_pkg::cmd_item_t make_arm(logic [3:0] slot_idx,
                                                     logic [31:0] exp_ms,
                                                     logic [23:0] intv, logic keep_f,
                                                     logic reset_f, logic [31:0] id);
        mtes_pkg::cmd_item_t c;
        c             = random_fill();
        c.command     = mtes_pkg::CMD_ARM;
        c.slot        = slot_idx;
        c.expire_ms   = exp_ms;
        c.interval_cs = intv;
        c.keep_flag   = keep_f;
        c.reset_flag  = reset_f;
        c.timer_id    = id;
        return c;
    endfunction

    function automatic mtes_pkg::cmd_item_t make_scan(logic [31:0] now);
        mtes_pkg::cmd_item_t c;
        c         = random_fill();
        c.command = mtes_pkg::CMD_SCAN;
        c.now_ms  = now;
        return c;
    endfunction

    function automatic mtes_pkg::cmd_item_t make_clear(logic [3:0] slot_idx);
        mtes_pkg::cmd_item_t c;
        c         = random_fill();
        c.command = mtes_pkg::CMD_CLEAR;
        c.slot    = slot_idx;
        return c;
    endfunction

    // Mostly arms near the running time and scans that move it forward, so
    // timers keep expiring; some clears, time jumps and pure noise.
    function automatic mtes_pkg::cmd_item_t next_random_command();
        mtes_pkg::cmd_item_t c;
        int        pick;
        logic [23:0] intv;
        pick = $urandom_range(0, 99);
        if (pick < 12)
        begin
            c = random_fill();
        end
        else if (pick < 45)
        begin
            intv = ($urandom_range(0, 7) == 0) ? 24'($urandom) : 24'($urandom_range(0, 40));
            c = make_arm(4'($urandom), clock_ms + $urandom_range(0, 800) - 32'd200,
                         intv, 1'($urandom), 1'($urandom), $urandom);
        end
        else if (pick < 55)
        begin
            c = make_clear(4'($urandom));
        end
        else
        begin
            clock_ms = clock_ms + $urandom_range(0, 300);
            if ($urandom_range(0, 19) == 0)
                clock_ms = $urandom;
            else if ($urandom_range(0, 29) == 0)
                clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 2000);
            c = make_scan(clock_ms);
        end
        return c;
    endfunction

    // Main sequence.
    initial
    begin
        mtes_pkg::cmd_item_t c;
        int        counted;
        logic [15:0] phase_wait [4];
        sb = new();
        clock_ms = 32'd1000;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, fire/free/disable/rearm, clamp, saturation.
        set_default_wait(16'hFFFF);
        issue(make_scan(32'd0));
        issue(make_arm(4'd0, 32'd0, 24'd0, 1'b1, 1'b1, 32'hFFFF_FFFF));
        issue(make_arm(4'd15, 32'hFFFF_FFFF, 24'hFF_FFFF, 1'b0, 1'b0, 32'd0));
        issue(make_arm(4'd7, 32'd100, 24'd0, 1'b1, 1'b0, 32'hA5A5_A5A5));
        issue(make_arm(4'd3, 32'd50, 24'd1, 1'b1, 1'b1, 32'h5A5A_5A5A));
        issue(make_scan(32'd100));
        issue(make_scan(32'd99));
        issue(make_clear(4'd3));
        c = random_fill();
        c.command = CMD_UNKNOWN;
        issue(c);
        issue(make_arm(4'd9, 32'd200000, 24'd0, 1'b0, 1'b1, 32'd1));
        issue(make_scan(32'd100));
        issue(make_scan(32'hFFFF_FF00));
        issue(make_scan(32'hFFFF_FFFF));
        issue(make_arm(4'd7, 32'hFFFF_FFFF, 24'hFF_FFFF, 1'b1, 1'b1, 32'h0000_0007));
        issue(make_scan(32'hFFFF_FFFF));
        issue(make_clear(4'd0));
        issue(make_clear(4'd7));
        issue(make_clear(4'd15));

        // A zero default wait is reported as one.
        set_default_wait(16'd0);
        issue(make_scan(32'd5));
        set_default_wait(16'd1);
        issue(make_arm(4'd4, 32'd1000, 24'd12, 1'b0, 1'b0, 32'h0000_0004));
        issue(make_scan(32'd0));
        issue(make_clear(4'd4));

        // Random phases under different default waits.
        phase_wait[0] = 16'd1;
        phase_wait[1] = 16'hFFFF;
        phase_wait[2] = 16'($urandom_range(2, 65534));
        phase_wait[3] = mtes_pkg::DEFAULT_WAIT_RST;
        for (int ph = 0; ph < 4; ph++)
        begin
            set_default_wait(phase_wait[ph]);
            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                // Long result hold-off while commands keep coming.
                if (ph == 1 && counted == 10)
                    hold_request = 1'b1;
                // Sender waits until every pending result is out.
                if (ph == 2 && counted == 25)
                    drain();
                c = next_random_command();
                issue(c);
                if (c.command != CMD_UNKNOWN)
                    counted++;
            end
        end

        drain();
        repeat (SETTLE) @(posedge clk);
        if (sb.errors == 0)
            $display("multi_timer_expiry_scan_tb: PASS");
        else
            $display("multi_timer_expiry_scan_tb: FAIL");
        $finish;
    end

endmodule
